[rtl/hhde_pkg.sv]
// Shared types and constants for the hex half-disk row enumerator.
`default_nettype none

package hhde_pkg;

    localparam int RADIUS_MAX_DEF = 31;   // default scan half-width minus one
    localparam int THR_W          = 12;   // radius threshold width
    localparam int EY_W           = 6;    // scanline offset width
    localparam int EX_W           = 7;    // column offset width, signed
    localparam int OP_W           = 8;    // squarer operand width, signed
    localparam int SQ_W           = 13;   // square of an operand up to 65
    localparam int BASE_W         = 14;   // 3*ey^2 up to 11907
    localparam int LHS_W          = 15;   // h^2 + 3*ey^2

    typedef struct packed {
        logic [EY_W-1:0] row_offset;
        logic            center_row_odd;
    } t_in_item;

    typedef struct packed {
        logic signed [EX_W-1:0] col_offset;
        logic [EY_W-1:0]        row_echo;
        logic                   row_empty;
        logic                   last_of_row;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BASE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

[rtl/hhde_sq_unit.sv]
// Shared squarer used for both the row term and the per-column term.
`default_nettype none

module hhde_sq_unit (
    input  wire logic signed [hhde_pkg::OP_W-1:0] i_op,
    output logic [hhde_pkg::SQ_W-1:0]             o_sq
);
    import hhde_pkg::*;

    logic signed [2*OP_W-1:0] prod;

    // operands stay within +/-65, so the square fits SQ_W bits
    assign prod = i_op * i_op;
    assign o_sq = prod[SQ_W-1:0];

endmodule

`default_nettype wire

[rtl/hex_half_disk_row_enumerator.sv]
// Top level: hex grid half-disk scanline enumerator with its sequencer.
`default_nettype none

// Usage
//   Write the radius threshold ceil(4r^2/sx^2) through i_cfg_we/i_cfg_wdata
//   while busy is low. Reset clears it to zero, which makes every row empty.
//   Issue a scanline by raising start with i_item (row offset ey and the
//   parity of the center row); the item is taken on an edge where start is
//   high and busy is low. busy then stays high until the row is finished.
//   Each pixel offset ex inside the disk comes out on o_result for one cycle,
//   marked by o_res_strobe, in ascending order; the final one carries
//   last_of_row. A row with no pixel gives one result with row_empty set.
//   Steps: the row term 3*ey^2 is first loaded through the shared squarer,
//   then the columns of the window -(RADIUS_MAX+1)..RADIUS_MAX+1 are tested
//   one per cycle on the same squarer, then a closing step ends the row; the
//   center scanline tests only columns 1..RADIUS_MAX+1. At most one result
//   per cycle. The squarer is the only multiplier.
//   Each hit is held until the next hit or the closing cycle so the last one
//   can be flagged. The receiver cannot stall; results are never held.
module hex_half_disk_row_enumerator #(
    parameter int RADIUS_MAX = hhde_pkg::RADIUS_MAX_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hhde_pkg::THR_W-1:0] i_cfg_wdata,
    input  wire logic                       start,
    input  wire hhde_pkg::t_in_item         i_item,
    output logic                            busy,
    output logic                            o_res_strobe,
    output hhde_pkg::t_out_item             o_result
);
    import hhde_pkg::*;

    // scan window bounds
    localparam logic signed [EX_W-1:0] EX_HI = EX_W'(RADIUS_MAX + 1);
    localparam logic signed [EX_W-1:0] EX_LO = -EX_HI;

    t_state                 r_state, n_state;
    logic [THR_W-1:0]       r_thr;
    logic [EY_W-1:0]        r_ey, n_ey;
    logic                   r_codd, n_codd;
    logic signed [EX_W-1:0] r_ex, n_ex;
    logic [BASE_W-1:0]      r_base, n_base;
    logic                   r_have, n_have;
    logic signed [EX_W-1:0] r_pend, n_pend;
    logic                   r_strobe, n_strobe;
    t_out_item              r_result, n_result;

    logic signed [OP_W-1:0] sq_op;
    logic [SQ_W-1:0]        sq;
    logic signed [OP_W-1:0] d_off;
    logic signed [OP_W-1:0] h_val;
    logic [LHS_W-1:0]       lhs;
    logic                   hit;

    hhde_sq_unit u_sq (
        .i_op (sq_op),
        .o_sq (sq)
    );

    // odd scanlines sit half a step right or left of the center row
    assign d_off = r_ey[0] ? (r_codd ? -8'sd1 : 8'sd1) : 8'sd0;
    assign h_val = $signed({r_ex, 1'b0}) + d_off;
    assign lhs   = LHS_W'(sq) + LHS_W'(r_base);
    assign hit   = lhs < LHS_W'(r_thr);

    assign busy         = (r_state != S_IDLE);
    assign o_res_strobe = r_strobe;
    assign o_result     = r_result;

    always_comb begin
        n_state  = r_state;
        n_ey     = r_ey;
        n_codd   = r_codd;
        n_ex     = r_ex;
        n_base   = r_base;
        n_have   = r_have;
        n_pend   = r_pend;
        n_strobe = 1'b0;
        n_result = r_result;
        sq_op    = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ey    = i_item.row_offset;
                    n_codd  = i_item.center_row_odd;
                    // the center scanline keeps only the right half
                    n_ex    = (i_item.row_offset == '0) ? EX_W'(1) : EX_LO;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                // load 3*ey^2 as sq + 2*sq
                sq_op   = $signed(OP_W'(r_ey));
                n_base  = BASE_W'(sq) + BASE_W'({sq, 1'b0});
                n_have  = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                sq_op = h_val;
                if (hit) begin
                    // release the held hit, it is not the last one
                    if (r_have) begin
                        n_strobe             = 1'b1;
                        n_result.col_offset  = r_pend;
                        n_result.row_echo    = r_ey;
                        n_result.row_empty   = 1'b0;
                        n_result.last_of_row = 1'b0;
                    end
                    n_pend = r_ex;
                    n_have = 1'b1;
                end
                if (r_ex == EX_HI) begin
                    n_state = S_FIN;
                end else begin
                    n_ex = r_ex + EX_W'(1);
                end
            end
            S_FIN: begin
                n_strobe             = 1'b1;
                n_result.row_echo    = r_ey;
                n_result.last_of_row = 1'b1;
                if (r_have) begin
                    n_result.col_offset = r_pend;
                    n_result.row_empty  = 1'b0;
                end else begin
                    n_result.col_offset = '0;
                    n_result.row_empty  = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thr    <= '0;
            r_strobe <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_have   <= n_have;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ey     <= n_ey;
        r_codd   <= n_codd;
        r_ex     <= n_ex;
        r_base   <= n_base;
        r_pend   <= n_pend;
        r_result <= n_result;
    end

    // closing a row always puts out its last result
    a_fin_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_res_strobe && o_result.last_of_row))
        else $error("row closed without a last result");

    // an empty row is a single result
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.row_empty) |-> o_result.last_of_row)
        else $error("empty result not flagged last");

    // nothing comes out while the row term is loaded
    a_base_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BASE) |-> !o_res_strobe)
        else $error("result during row setup");

    // every pixel lies in the scan window
    a_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_result.row_empty) |->
            (o_result.col_offset >= EX_LO && o_result.col_offset <= EX_HI))
        else $error("column offset outside scan window");

endmodule

`default_nettype wire

[test/hex_half_disk_row_enumerator_tb.sv]
// Self-checking testbench for the hex half-disk scanline enumerator.
module hex_half_disk_row_enumerator_tb;

    import hhde_pkg::*;

    // Scan window half-width, cycles one row takes, and the run limits.
    localparam int SCAN_LIM    = RADIUS_MAX_DEF + 1;
    localparam int ROW_CYCLES  = 2 * RADIUS_MAX_DEF + 6;
    localparam int MAX_GAP     = ROW_CYCLES + 12;
    localparam int TAIL_LIMIT  = 8 * ROW_CYCLES;
    localparam int CYCLE_LIMIT = 250000;
    localparam int MAX_PRINTS  = 40;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [THR_W-1:0]   i_cfg_wdata = '0;
    logic               start       = 1'b0;
    t_in_item           i_item      = '0;
    logic               busy;
    logic               o_res_strobe;
    t_out_item          o_result;

    // Pixels still owed by the block, oldest first, and the threshold in force.
    t_out_item          pixel_q[$];
    logic [THR_W-1:0]   thr_model = '0;

    int                 idle_pct   = 0;
    int                 mism_cnt   = 0;
    int                 row_cnt    = 0;
    int                 pixel_cnt  = 0;
    int                 thr_writes = 0;
    int                 cycle_cnt  = 0;

    t_out_item          got_px;
    t_out_item          want_px;

    hex_half_disk_row_enumerator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .i_item       (i_item),
        .busy         (busy),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string msg);
        if (mism_cnt < MAX_PRINTS) begin
            $display("MISMATCH @%0d: %s", cycle_cnt, msg);
        end
        mism_cnt++;
    endtask

    // Work out every pixel of one scanline under the current threshold.
    // The latest hit is held back so the final one can be flagged as last.
    function automatic void predict_row(input t_in_item it);
        int        ey;
        int        d;
        int        lo;
        int        ex;
        int        h;
        bit        have_px;
        t_out_item held;
        ey      = it.row_offset;
        d       = 0;
        have_px = 1'b0;
        held    = '0;
        // Odd scanlines sit half a step off; the center row parity picks the side.
        if (ey % 2 == 1) begin
            d = it.center_row_odd ? -1 : 1;
        end
        // On the center scanline keep only the right half.
        lo = (ey == 0) ? 1 : -SCAN_LIM;
        for (ex = lo; ex <= SCAN_LIM; ex++) begin
            h = 2 * ex + d;
            if (h * h + 3 * ey * ey < int'(thr_model)) begin
                if (have_px) begin
                    pixel_q.push_back(held);
                end
                held.col_offset  = ex[EX_W-1:0];
                held.row_echo    = it.row_offset;
                held.row_empty   = 1'b0;
                held.last_of_row = 1'b0;
                have_px          = 1'b1;
            end
        end
        if (have_px) begin
            held.last_of_row = 1'b1;
        end else begin
            // No pixel inside the disk: one marker item for the row.
            held.col_offset  = '0;
            held.row_echo    = it.row_offset;
            held.row_empty   = 1'b1;
            held.last_of_row = 1'b1;
        end
        pixel_q.push_back(held);
    endfunction

    // Offer one scanline item, after an optional random idle gap, and hold it
    // until the block takes it. Start stays high into the next call when no
    // gap follows, so it is never dropped and raised in one step.
    task automatic send_row(input t_in_item it);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, MAX_GAP);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Taken at this edge: the expected pixels follow from the threshold now.
        predict_row(it);
        row_cnt++;
    endtask

    task automatic send_ey(input int ey, input bit odd);
        t_in_item it;
        it.row_offset     = ey[EY_W-1:0];
        it.center_row_odd = odd;
        send_row(it);
    endtask

    // Drop start and wait until every owed pixel is out and the block is idle,
    // then give it the latency of a row on top.
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0 || busy) @(posedge i_clk);
        repeat (ROW_CYCLES) @(posedge i_clk);
    endtask

    // Write the radius threshold while the block is idle.
    task automatic write_thr(input logic [THR_W-1:0] thr);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        thr_model = thr;
        thr_writes++;
        i_cfg_we    <= 1'b0;
    endtask

    // After reset the threshold is zero: every row comes out empty.
    task automatic test_reset_threshold();
        send_ey(0, 1'b0);
        send_ey(1, 1'b1);
        send_ey(63, 1'b0);
    endtask

    // Largest threshold: the widest rows, the 64-pixel odd row, and the
    // scanlines just inside and outside the disk.
    task automatic test_full_threshold();
        write_thr('1);
        send_ey(0, 1'b0);
        send_ey(1, 1'b0);
        send_ey(1, 1'b1);
        send_ey(2, 1'b1);
        send_ey(36, 1'b0);
        send_ey(37, 1'b1);
        send_ey(63, 1'b1);
    endtask

    // Tiny thresholds: center row empty or holding one pixel, and the
    // half-step shift on the first odd row flipping with center parity.
    task automatic test_small_threshold();
        write_thr(12'd4);
        send_ey(0, 1'b1);
        write_thr(12'd5);
        send_ey(0, 1'b0);
        send_ey(1, 1'b0);
        send_ey(1, 1'b1);
        write_thr(12'd2);
        send_ey(0, 1'b0);
    endtask

    // Mid threshold: even and odd rows under both center parities, and an
    // odd row beyond the disk.
    task automatic test_parity();
        write_thr(12'd1000);
        send_ey(5, 1'b0);
        send_ey(5, 1'b1);
        send_ey(6, 1'b0);
        send_ey(6, 1'b1);
        send_ey(21, 1'b1);
    endtask

    // Random threshold, leaning on the extremes and on small disks.
    function automatic logic [THR_W-1:0] pick_thr();
        case ($urandom_range(3))
            0:       pick_thr = THR_W'($urandom_range(0, 4095));
            1:       pick_thr = THR_W'($urandom_range(1, 300));
            2:       pick_thr = '1;
            default: pick_thr = THR_W'($urandom_range(3000, 4095));
        endcase
    endfunction

    // Random scanlines: mostly inside the disk, the rest anywhere.
    task automatic test_random(input int sender_idle, input int n_rows);
        int i;
        int top_ey;
        int ey;
        idle_pct = sender_idle;
        top_ey   = 0;
        for (i = 0; i < n_rows; i++) begin
            // Switch the disk every so often; the write waits for a drain.
            if (i % 30 == 0) begin
                write_thr(pick_thr());
                top_ey = 0;
                while (top_ey < 63 && 3 * (top_ey + 1) * (top_ey + 1) < int'(thr_model)) begin
                    top_ey++;
                end
            end
            // Pause once mid-phase until the block has caught up.
            if (i == n_rows / 2) begin
                wait_drain();
            end
            if ($urandom_range(99) < 85) begin
                ey = $urandom_range(0, (top_ey < 63) ? top_ey + 1 : 63);
            end else begin
                ey = $urandom_range(0, 63);
            end
            send_ey(ey, 1'(($urandom_range(1))));
        end
    endtask

    // Compare each strobed pixel with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            got_px = o_result;
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel ex=%0d ey=%0d",
                    got_px.col_offset, got_px.row_echo));
            end else begin
                want_px = pixel_q.pop_front();
                if (got_px.col_offset !== want_px.col_offset ||
                    got_px.row_echo !== want_px.row_echo ||
                    got_px.row_empty !== want_px.row_empty ||
                    got_px.last_of_row !== want_px.last_of_row) begin
                    report_mismatch($sformatf(
                        "got ex=%0d ey=%0d empty=%0b last=%0b, want ex=%0d ey=%0d empty=%0b last=%0b",
                        got_px.col_offset, got_px.row_echo, got_px.row_empty,
                        got_px.last_of_row, want_px.col_offset, want_px.row_echo,
                        want_px.row_empty, want_px.last_of_row));
                end
                pixel_cnt++;
            end
        end
    end

    // Watchdog: end the run if it goes far past the slowest correct run.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TIMEOUT after %0d cycles, %0d pixels still owed", cycle_cnt,
            pixel_q.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int tail;
        // Hold reset at the start, then release it for good.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 0;
        test_reset_threshold();
        test_full_threshold();
        test_small_threshold();
        test_parity();

        // Sender sparse gaps, then heavy gaps, then back to back.
        test_random(9, 86);
        test_random(77, 86);
        test_random(0, 88);

        // Drain the last row, bounded, and leave a row's latency on top.
        start <= 1'b0;
        tail = 0;
        @(posedge i_clk);
        while ((pixel_q.size() != 0 || busy) && tail < TAIL_LIMIT) begin
            @(posedge i_clk);
            tail++;
        end
        repeat (ROW_CYCLES) @(posedge i_clk);
        if (pixel_q.size() != 0) begin
            report_mismatch($sformatf("%0d pixels never came out", pixel_q.size()));
        end

        $display("Covered %0d scanlines, %0d pixels checked, %0d threshold writes.",
            row_cnt, pixel_cnt, thr_writes);
        $display("Mismatches: %0d over %0d cycles.", mism_cnt, cycle_cnt);
        if (mism_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
